// ===== design/dfc_pkg.sv =====
// ----------------------------------------------------------------------------
// dfc_pkg
// shared types, constants and helpers of the depth false colour map
// ----------------------------------------------------------------------------
`default_nettype none

package dfc_pkg;

  // number of gamma table levels, a power of two
  localparam int unsigned DEPTH_LEVELS = 2048;
  localparam int unsigned HALF_LEVELS  = DEPTH_LEVELS / 2;
  localparam int unsigned IDX_W        = $clog2(DEPTH_LEVELS);
  localparam int unsigned Q_W          = IDX_W - 1;

  // field widths
  localparam int unsigned RAW_W   = 32;
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned GAMMA_W = 14;

  // disparity path: depth = floor((2 * 600000 + v) / (2 * v))
  localparam int unsigned DISP_SCALE = 1200000;
  localparam int unsigned DEN_W      = SMP_W + 1;
  localparam int unsigned REM_W      = DEN_W + Q_W;
  localparam int unsigned DIV_STEPS  = 2;
  localparam int unsigned DIV_STAGES = (Q_W + DIV_STEPS - 1) / DIV_STEPS;

  // metre path: depth = (2000 * m + 0.5) in Q16.16
  localparam int unsigned METRE_SCALE = 2000;
  localparam int unsigned METRE_FRAC  = 16;
  localparam int unsigned METRE_ROUND = 32768;
  localparam int unsigned MPROD_W     = RAW_W + 11;
  localparam int unsigned MD_W        = MPROD_W - METRE_FRAC;

  // cubic gamma: floor(9216 * i^3 / DEPTH_LEVELS^3)
  localparam int unsigned GAMMA_SCALE = 9216;
  localparam int unsigned SQ_W        = 2 * IDX_W;
  localparam int unsigned CUBE_W      = 3 * IDX_W;
  localparam int unsigned GPROD_W     = CUBE_W + 15;

  // pipeline stage positions
  localparam int unsigned ST_IN    = 0;
  localparam int unsigned ST_PREP  = 1;
  localparam int unsigned ST_DIV   = 2;
  localparam int unsigned ST_SQ    = ST_DIV + DIV_STAGES;
  localparam int unsigned ST_CUBE  = ST_SQ + 1;
  localparam int unsigned ST_GAMMA = ST_CUBE + 1;
  localparam int unsigned N_STG    = ST_GAMMA + 1;

  // colour ramp selected by the gamma bits above the low byte
  localparam logic [GAMMA_W-CH_W-1:0] RAMP_WHITE_RED  = 6'd0;
  localparam logic [GAMMA_W-CH_W-1:0] RAMP_RED_YEL    = 6'd1;
  localparam logic [GAMMA_W-CH_W-1:0] RAMP_YEL_GREEN  = 6'd2;
  localparam logic [GAMMA_W-CH_W-1:0] RAMP_GREEN_CYAN = 6'd3;
  localparam logic [GAMMA_W-CH_W-1:0] RAMP_CYAN_BLUE  = 6'd4;
  localparam logic [GAMMA_W-CH_W-1:0] RAMP_BLUE_BLACK = 6'd5;

  typedef enum logic [MODE_W-1:0] {
    MODE_DISP   = 2'd0,
    MODE_MM     = 2'd1,
    MODE_METRE  = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  // divider / depth word carried through the division stages
  typedef struct packed {
    logic             black;
    logic             div;
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   q;
  } div_t;

  // beat handed to the colour stage
  typedef struct packed {
    logic               black;
    logic [GAMMA_W-1:0] gamma;
  } col_t;

  // one restoring division step for quotient bit b
  function automatic div_t div_step(div_t s, int unsigned b);
    div_t             r;
    logic [REM_W-1:0] trial;
    r     = s;
    trial = REM_W'(s.den) << b;
    if (s.div && s.rem >= trial) begin
      r.rem  = s.rem - trial;
      r.q[b] = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/dfc_if.sv =====
// ----------------------------------------------------------------------------
// dfc_if
// valid/ready channels of the depth false colour map
// ----------------------------------------------------------------------------
`default_nettype none

interface dfc_cfg_if import dfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] source_mode;
  modport source(output valid, source_mode, input ready);
  modport sink(input valid, source_mode, output ready);
endinterface

interface dfc_pix_if import dfc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_value;
  modport source(output valid, raw_value, input ready);
  modport sink(input valid, raw_value, output ready);
endinterface

interface dfc_rgb_if import dfc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  modport source(output valid, red, green, blue, input ready);
  modport sink(input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

// ===== design/dfc_color.sv =====
// ----------------------------------------------------------------------------
// dfc_color
// colour ramp lookup and output register
// ----------------------------------------------------------------------------
`default_nettype none

module dfc_color import dfc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  col_t       in_col,
  dfc_rgb_if.source  rgb
);

  logic [GAMMA_W-CH_W-1:0] hb;
  logic [CH_W-1:0]         lb;
  logic [CH_W-1:0]         red_next;
  logic [CH_W-1:0]         green_next;
  logic [CH_W-1:0]         blue_next;

  assign in_ready = !rgb.valid || rgb.ready;
  assign hb       = in_col.gamma[GAMMA_W-1:CH_W];
  assign lb       = in_col.gamma[CH_W-1:0];

  always_comb begin
    red_next   = '0;
    green_next = '0;
    blue_next  = '0;
    if (!in_col.black) begin
      case (hb)
        RAMP_WHITE_RED: begin
          red_next   = '1;
          green_next = ~lb;
          blue_next  = ~lb;
        end
        RAMP_RED_YEL: begin
          red_next   = '1;
          green_next = lb;
        end
        RAMP_YEL_GREEN: begin
          red_next   = ~lb;
          green_next = '1;
        end
        RAMP_GREEN_CYAN: begin
          green_next = '1;
          blue_next  = lb;
        end
        RAMP_CYAN_BLUE: begin
          green_next = ~lb;
          blue_next  = '1;
        end
        RAMP_BLUE_BLACK: begin
          blue_next  = ~lb;
        end
        default: begin
          red_next   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rgb.valid <= 1'b0;
    end else if (in_ready) begin
      rgb.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rgb.red   <= red_next;
      rgb.green <= green_next;
      rgb.blue  <= blue_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/depth_false_color_map.sv =====
// ----------------------------------------------------------------------------
// depth_false_color_map
// depth / disparity pixel stream to rgb false colour
// ----------------------------------------------------------------------------
// takes one pixel beat per clock while nothing stalls and returns one rgb
// beat per pixel, in order, through ten pipeline stages and the output
// register. the disparity divide is the longest part and retires two
// quotient bits per stage over five stages; the cubic gamma
// curve is evaluated with two registered multiplies instead of a stored
// table, so there is no memory and no clearing pass after reset. every stage
// has its own valid bit and holds when the next one is full, so bubbles close
// up and a stall at the output loses nothing. source_mode is written through
// the cfg channel (always ready) and must only change while the pipe is empty
// ----------------------------------------------------------------------------
`default_nettype none

module depth_false_color_map import dfc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  dfc_cfg_if.sink   cfg,
  dfc_pix_if.sink   pix,
  dfc_rgb_if.source rgb
);

  // configuration register
  mode_t mode;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_DISP;
    end else if (cfg.valid) begin
      mode <= mode_t'(cfg.source_mode);
    end
  end

  // stage handshake: a stage takes a beat when it is empty or its
  // occupant moves on in the same clock
  logic [N_STG-1:0] vld;
  logic [N_STG:0]   rdy;
  logic [N_STG-1:0] up;
  logic [N_STG-1:0] load;
  logic             col_ready;

  assign rdy[N_STG] = col_ready;

  for (genvar k = 0; k < N_STG; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end

  assign up        = {vld[N_STG-2:0], pix.valid};
  assign load      = up & rdy[N_STG-1:0];
  assign pix.ready = rdy[ST_IN];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (vld & ~rdy[N_STG-1:0]) | (up & rdy[N_STG-1:0]);
    end
  end

  // stage in: metre scaling multiply, sample captured with its mode
  logic [MPROD_W-1:0] mprod_full;
  mode_t              in_mode;
  logic [SMP_W-1:0]   in_smp;
  logic [MD_W-1:0]    in_md;

  assign mprod_full = MPROD_W'(pix.raw_value) * MPROD_W'(METRE_SCALE)
                    + MPROD_W'(METRE_ROUND);

  always_ff @(posedge clk) begin
    if (load[ST_IN]) begin
      in_mode <= mode;
      in_smp  <= pix.raw_value[SMP_W-1:0];
      in_md   <= mprod_full[MPROD_W-1:METRE_FRAC];
    end
  end

  // stage prep: per-mode depth, range check, divider set-up
  div_t prep_next;
  div_t prep;

  always_comb begin
    prep_next = '0;
    case (in_mode)
      MODE_DISP: begin
        // zero disparity stays at depth zero
        if (in_smp != '0) begin
          prep_next.rem   = REM_W'(DISP_SCALE) + REM_W'(in_smp);
          prep_next.den   = {in_smp, 1'b0};
          // quotient past the table half is black
          prep_next.black = prep_next.rem >= (REM_W'(prep_next.den) << Q_W);
          prep_next.div   = !prep_next.black;
        end
      end
      MODE_MM: begin
        // negative millimetres are black
        prep_next.black = in_smp[SMP_W-1] ||
                          ({1'b0, in_smp} >= (SMP_W+1)'(HALF_LEVELS));
        prep_next.q     = in_smp[Q_W-1:0];
      end
      MODE_METRE: begin
        prep_next.black = in_md >= MD_W'(HALF_LEVELS);
        prep_next.q     = in_md[Q_W-1:0];
      end
      default: begin
        // unused mode reads as depth zero
        prep_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load[ST_PREP]) begin
      prep <= prep_next;
    end
  end

  // divider stages: restoring division, two quotient bits per stage,
  // other modes pass straight through
  div_t dv_in [DIV_STAGES];
  div_t dv    [DIV_STAGES];

  assign dv_in[0] = prep;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    div_t step_next;

    if (k > 0) begin : g_link
      assign dv_in[k] = dv[k-1];
    end

    always_comb begin
      step_next = dv_in[k];
      for (int j = 0; j < DIV_STEPS; j++) begin
        if (k * DIV_STEPS + j < Q_W) begin
          step_next = div_step(step_next, Q_W - 1 - (k * DIV_STEPS + j));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (load[ST_DIV+k]) begin
        dv[k] <= step_next;
      end
    end
  end

  // gamma stages: table index is twice the depth, curve is 9216 * i^3 / N^3
  logic [IDX_W-1:0]   sq_idx;
  logic [SQ_W-1:0]    sq_val;
  logic               sq_black;
  logic [IDX_W-1:0]   idx_next;
  logic [CUBE_W-1:0]  cube_val;
  logic               cube_black;
  logic [GPROD_W-1:0] gprod;
  col_t               gam;

  assign idx_next = {dv[DIV_STAGES-1].q, 1'b0};

  always_ff @(posedge clk) begin
    if (load[ST_SQ]) begin
      sq_idx   <= idx_next;
      sq_val   <= SQ_W'(idx_next) * SQ_W'(idx_next);
      sq_black <= dv[DIV_STAGES-1].black;
    end
  end

  always_ff @(posedge clk) begin
    if (load[ST_CUBE]) begin
      cube_val   <= CUBE_W'(sq_val) * CUBE_W'(sq_idx);
      cube_black <= sq_black;
    end
  end

  // constant scale, a shift-and-add
  assign gprod = GPROD_W'(cube_val) * GPROD_W'(GAMMA_SCALE);

  always_ff @(posedge clk) begin
    if (load[ST_GAMMA]) begin
      gam.black <= cube_black;
      gam.gamma <= gprod[CUBE_W +: GAMMA_W];
    end
  end

  // ramp select and output register
  dfc_color u_color (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld[ST_GAMMA]),
    .in_ready (col_ready),
    .in_col   (gam),
    .rgb      (rgb)
  );

endmodule

`default_nettype wire
